@@ hw/rtl/pfa_pkg.sv @@
// Shared types and constants of the page frame allocator.
package pfa_pkg;

  localparam int unsigned NUM_FRAMES = 64;
  localparam int unsigned NUM_OWNERS = 16;

  localparam int unsigned PageSizeW  = 16;
  localparam int unsigned ActiveW    = 7;
  localparam int unsigned ReqW       = 22;
  localparam int unsigned OwnerW     = 4;
  localparam int unsigned FrameIdxW  = 6;
  localparam int unsigned FreePagesW = 7;
  localparam logic [ReqW-1:0] ByteMax = {ReqW{1'b1}};
  localparam logic [PageSizeW-1:0] PageSizeRst = 16'd4096;
  localparam logic [ActiveW-1:0]   ActiveRst   = 7'd64;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam int unsigned RegIdxW = 1;
  localparam logic [RegIdxW-1:0] REG_PAGE_SIZE = 1'b0;
  localparam logic [RegIdxW-1:0] REG_ACTIVE    = 1'b1;

  // Divider status towards the sequencer.
  typedef struct packed {
    logic               done;
    logic [ReqW-1:0]    quot;
    logic [PageSizeW-1:0] rem;
  } div_res_t;

endpackage

@@ hw/rtl/pfa_div.sv @@
// Restoring divider, one quotient bit per cycle.
module pfa_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pfa_pkg::ReqW-1:0]      dividend_i,
  input  logic [pfa_pkg::PageSizeW-1:0] divisor_i,
  output pfa_pkg::div_res_t             res_o
);
  import pfa_pkg::*;

  localparam int unsigned CntW = $clog2(ReqW + 1);

  logic [ReqW-1:0]      q_q, q_d;
  logic [PageSizeW:0]   r_q, r_d;
  logic [PageSizeW-1:0] dv_q, dv_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 run_q, run_d, done_q, done_d;
  logic [PageSizeW+1:0] trial;

  always_comb begin
    q_d = q_q; r_d = r_q; dv_d = dv_q; cnt_d = cnt_q; run_d = run_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      q_d = dividend_i; r_d = '0; dv_d = divisor_i;
      cnt_d = CntW'(ReqW); run_d = 1'b1;
    end else if (run_q) begin
      trial = {r_q, q_q[ReqW-1]} - {2'b00, dv_q};
      if (!trial[PageSizeW+1]) begin
        r_d = trial[PageSizeW:0];
        q_d = {q_q[ReqW-2:0], 1'b1};
      end else begin
        r_d = {r_q[PageSizeW-1:0], q_q[ReqW-1]};
        q_d = {q_q[ReqW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; dv_q <= dv_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = q_q;
  assign res_o.rem  = r_q[PageSizeW-1:0];
endmodule

@@ hw/rtl/page_frame_allocator.sv @@
// Page frame allocator top level: sequencer, frame table and config port.
// Free is one pass over the window; allocate runs the division and check, then, unless the
// request is rejected or empty, one run search pass and one assignment pass over the window.
// One request at a time; busy falls with a non-frame result, or the cycle after the last frame result.
// A window recount after reset or an active_frames write runs with busy high.
// Reset: every frame free, page size 4096, 64 active frames; results cannot stall.
module page_frame_allocator (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic start,
  output logic busy,
  input  logic mode_i,
  input  logic [pfa_pkg::OwnerW-1:0] owner_id_i,
  input  logic [pfa_pkg::ReqW-1:0] request_bytes_i,
  output logic result_valid_o,
  output logic status_o,
  output logic frame_valid_o,
  output logic [pfa_pkg::FrameIdxW-1:0] frame_index_o,
  output logic [pfa_pkg::PageSizeW-1:0] bytes_in_frame_o,
  output logic contiguous_o,
  output logic [pfa_pkg::ReqW-1:0] freed_bytes_o,
  output logic [pfa_pkg::FreePagesW-1:0] free_pages_o,
  output logic last_o
);
  import pfa_pkg::*;

  localparam int unsigned FW = $clog2(NUM_FRAMES);
  localparam int unsigned CW = $clog2(NUM_FRAMES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RECNT, S_FREE, S_DIV, S_CHECK, S_SEARCH, S_ASSIGN, S_DONE
  } state_e;

  state_e state_q;
  logic [PageSizeW-1:0] page_size_q;
  logic [ActiveW-1:0]   active_q;
  logic [CW-1:0]        free_cnt_q;
  logic [ReqW-1:0]      used_total_q;

  logic                 used_q [NUM_FRAMES];
  logic [OwnerW-1:0]    owner_mem [NUM_FRAMES];
  logic [PageSizeW-1:0] bytes_mem [NUM_FRAMES];
  logic [OwnerW-1:0]    own_rd_q;
  logic [PageSizeW-1:0] bytes_rd_q;

  logic [OwnerW-1:0]    own_q;
  logic [ReqW-1:0]      req_q, acc_q, pages_q;
  logic [PageSizeW-1:0] last_bytes_q, ps_q;
  logic [CW-1:0]        idx_q, run_q, start_q, cnt_q;
  logic                 found_q;
  logic                 pv_q;
  logic [FW-1:0]        pidx_q;

  logic [PageSizeW-1:0] ps_eff;
  logic [CW-1:0]        win;
  logic                 cfg_wr, div_start;
  div_res_t             div_res;
  logic [FW-1:0]        fi;
  logic [ReqW:0]        sum;
  logic                 is_last, mem_we;
  logic [PageSizeW-1:0] frame_b;

  assign ps_eff = (page_size_q == '0) ? PageSizeW'(1) : page_size_q;
  assign win = (active_q > ActiveW'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : CW'(active_q);
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {25'd0, active_q} : {16'd0, page_size_q};
  assign busy = (state_q != S_IDLE);
  assign fi = idx_q[FW-1:0];
  assign div_start = start && !busy && mode_i == MODE_ALLOC;
  assign sum = {1'b0, acc_q} + {7'd0, bytes_rd_q};
  assign is_last = (ReqW'(cnt_q) + 1'b1 == pages_q);
  assign frame_b = is_last ? last_bytes_q : ps_q;
  assign mem_we = (state_q == S_ASSIGN) && !used_q[fi];

  pfa_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .dividend_i(request_bytes_i), .divisor_i(ps_eff), .res_o(div_res)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      owner_mem[fi] <= own_q;
      bytes_mem[fi] <= frame_b;
    end
    own_rd_q <= owner_mem[fi];
    bytes_rd_q <= bytes_mem[fi];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RECNT;
      page_size_q <= PageSizeRst;
      active_q <= ActiveRst;
      free_cnt_q <= '0;
      used_total_q <= '0;
      idx_q <= '0;
      for (int k = 0; k < NUM_FRAMES; k++) used_q[k] <= 1'b0;
      own_q <= '0; req_q <= '0; acc_q <= '0; pages_q <= '0;
      last_bytes_q <= '0; ps_q <= '0; run_q <= '0; start_q <= '0; cnt_q <= '0;
      found_q <= 1'b0; pv_q <= 1'b0; pidx_q <= '0;
      status_o <= 1'b0; frame_valid_o <= 1'b0; frame_index_o <= '0;
      bytes_in_frame_o <= '0; contiguous_o <= 1'b0; freed_bytes_o <= '0;
      free_pages_o <= '0; last_o <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_wr && state_q == S_IDLE) begin
        if (paddr[2] == REG_ACTIVE) begin
          active_q <= pwdata[ActiveW-1:0];
          state_q <= S_RECNT; idx_q <= '0; free_cnt_q <= '0;
        end else page_size_q <= pwdata[PageSizeW-1:0];
      end else begin
        case (state_q)
          S_IDLE: if (start) begin
            own_q <= owner_id_i; req_q <= request_bytes_i; ps_q <= ps_eff;
            idx_q <= '0; acc_q <= '0; run_q <= '0; start_q <= '0; cnt_q <= '0;
            found_q <= 1'b0; pv_q <= 1'b0;
            state_q <= (mode_i == MODE_FREE) ? S_FREE : S_DIV;
          end
          S_RECNT: begin
            if (idx_q >= win) state_q <= S_IDLE;
            else begin
              if (!used_q[fi]) free_cnt_q <= free_cnt_q + 1'b1;
              idx_q <= idx_q + 1'b1;
            end
          end
          S_FREE: begin
            if (pv_q && used_q[pidx_q] && own_rd_q == own_q) begin
              acc_q <= sum[ReqW] ? ByteMax : sum[ReqW-1:0];
              used_q[pidx_q] <= 1'b0;
              free_cnt_q <= free_cnt_q + 1'b1;
            end
            if (idx_q < win && 32'(own_q) < NUM_OWNERS) begin
              pv_q <= 1'b1; pidx_q <= fi;
              idx_q <= idx_q + 1'b1;
            end else begin
              pv_q <= 1'b0;
              if (!pv_q) begin
                used_total_q <= (used_total_q > acc_q) ? used_total_q - acc_q : '0;
                status_o <= 1'b0; frame_valid_o <= 1'b0; frame_index_o <= '0;
                bytes_in_frame_o <= '0; contiguous_o <= 1'b0; freed_bytes_o <= acc_q;
                free_pages_o <= FreePagesW'(free_cnt_q); last_o <= 1'b1;
                result_valid_o <= 1'b1;
                state_q <= S_IDLE;
              end
            end
          end
          S_DIV: if (div_res.done) begin
            pages_q <= div_res.quot + ReqW'(div_res.rem != '0);
            last_bytes_q <= (div_res.rem != '0) ? div_res.rem : ps_q;
            state_q <= S_CHECK;
          end
          S_CHECK: begin
            status_o <= 1'b0; frame_valid_o <= 1'b0; frame_index_o <= '0;
            bytes_in_frame_o <= '0; contiguous_o <= 1'b0; freed_bytes_o <= '0;
            free_pages_o <= FreePagesW'(free_cnt_q); last_o <= 1'b1;
            if (32'(own_q) >= NUM_OWNERS || pages_q > ReqW'(free_cnt_q)) begin
              status_o <= 1'b1; result_valid_o <= 1'b1; state_q <= S_IDLE;
            end else if (pages_q == '0) begin
              result_valid_o <= 1'b1; state_q <= S_IDLE;
            end else state_q <= S_SEARCH;
          end
          S_SEARCH: begin
            if (idx_q >= win) begin
              idx_q <= '0; state_q <= S_ASSIGN;
            end else if (!used_q[fi]) begin
              if (run_q == '0) start_q <= idx_q;
              run_q <= run_q + 1'b1;
              if (ReqW'(run_q) + 1'b1 == pages_q) begin
                found_q <= 1'b1;
                idx_q <= (run_q == '0) ? idx_q : start_q;
                state_q <= S_ASSIGN;
              end else idx_q <= idx_q + 1'b1;
            end else begin
              run_q <= '0; idx_q <= idx_q + 1'b1;
            end
          end
          S_ASSIGN: begin
            if (!used_q[fi]) begin
              used_q[fi] <= 1'b1;
              cnt_q <= cnt_q + 1'b1;
              status_o <= 1'b0; frame_valid_o <= 1'b1;
              frame_index_o <= FrameIdxW'(idx_q);
              bytes_in_frame_o <= frame_b;
              contiguous_o <= found_q; freed_bytes_o <= '0;
              free_pages_o <= FreePagesW'(free_cnt_q - CW'(pages_q));
              last_o <= is_last;
              result_valid_o <= 1'b1;
              if (is_last) begin
                free_cnt_q <= free_cnt_q - CW'(pages_q);
                state_q <= S_DONE;
              end
            end
            idx_q <= idx_q + 1'b1;
          end
          S_DONE: begin
            used_total_q <= ({1'b0, used_total_q} + {1'b0, req_q} > {1'b0, ByteMax})
                            ? ByteMax : used_total_q + req_q;
            state_q <= S_IDLE;
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end
endmodule

@@ verif/pfa_checker.sv @@
// Checker for the page frame allocator: tracks the frame table, predicts results, compares.
module pfa_checker
  import pfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  mode_i,
  input  logic [OwnerW-1:0]     owner_id_i,
  input  logic [ReqW-1:0]       request_bytes_i,
  input  logic                  result_valid_o,
  input  logic                  status_o,
  input  logic                  frame_valid_o,
  input  logic [FrameIdxW-1:0]  frame_index_o,
  input  logic [PageSizeW-1:0]  bytes_in_frame_o,
  input  logic                  contiguous_o,
  input  logic [ReqW-1:0]       freed_bytes_o,
  input  logic [FreePagesW-1:0] free_pages_o,
  input  logic                  last_o,
  output int                    pending_o,
  output int                    fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  status;
    logic                  frame_valid;
    logic [FrameIdxW-1:0]  frame_index;
    logic [PageSizeW-1:0]  bytes_in_frame;
    logic                  contiguous;
    logic [ReqW-1:0]       freed_bytes;
    logic [FreePagesW-1:0] free_pages;
    logic                  last;
  } frame_result_t;

  frame_result_t        expected_results[$];
  logic [PageSizeW-1:0] page_size;
  logic [ActiveW-1:0]   active_frames;
  logic                 used[NUM_FRAMES];
  logic [OwnerW-1:0]    owner_of[NUM_FRAMES];
  int unsigned          bytes_of[NUM_FRAMES];
  int unsigned          free_count;
  int unsigned          used_total;

  assign pending_o = expected_results.size();

  function automatic int unsigned window();
    return (active_frames < NUM_FRAMES) ? active_frames : NUM_FRAMES;
  endfunction

  function automatic void recount();
    free_count = 0;
    for (int i = 0; i < window(); i++) if (!used[i]) free_count++;
  endfunction

  function automatic void push_result(logic st, logic fv, int unsigned idx, int unsigned b,
                                      logic ct, int unsigned fb, logic lst);
    frame_result_t r;
    r.status = st;
    r.frame_valid = fv;
    r.frame_index = idx[FrameIdxW-1:0];
    r.bytes_in_frame = b[PageSizeW-1:0];
    r.contiguous = ct;
    r.freed_bytes = fb[ReqW-1:0];
    r.free_pages = free_count[FreePagesW-1:0];
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_request(logic md, logic [OwnerW-1:0] own,
                                          logic [ReqW-1:0] req);
    int unsigned ps, n, pages, last_bytes, run, first, cnt, freed;
    int unsigned picked[NUM_FRAMES];
    bit found;
    ps = (page_size == 0) ? 1 : page_size;
    n = window();
    if (md == MODE_FREE) begin
      freed = 0;
      if (own < NUM_OWNERS) begin
        for (int i = 0; i < n; i++) begin
          if (used[i] && owner_of[i] == own) begin
            freed += bytes_of[i];
            if (freed > ByteMax) freed = ByteMax;
            used[i] = 1'b0;
            owner_of[i] = '0;
            bytes_of[i] = 0;
            free_count++;
          end
        end
      end
      used_total = (used_total > freed) ? used_total - freed : 0;
      push_result(1'b0, 1'b0, 0, 0, 1'b0, freed, 1'b1);
      return;
    end
    pages = (req + ps - 1) / ps;
    last_bytes = (req % ps != 0) ? req % ps : ps;
    if (own >= NUM_OWNERS || pages > free_count) begin
      push_result(1'b1, 1'b0, 0, 0, 1'b0, 0, 1'b1);
      return;
    end
    if (pages == 0) begin
      push_result(1'b0, 1'b0, 0, 0, 1'b0, 0, 1'b1);
      return;
    end
    run = 0;
    first = 0;
    found = 0;
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      if (!used[i]) begin
        if (run == 0) first = i;
        run++;
        if (run == pages) begin
          found = 1;
          break;
        end
      end else begin
        run = 0;
      end
    end
    if (found) begin
      for (int i = 0; i < pages; i++) picked[cnt++] = first + i;
    end else begin
      for (int i = 0; i < n && cnt < pages; i++) if (!used[i]) picked[cnt++] = i;
    end
    for (int i = 0; i < cnt; i++) begin
      used[picked[i]] = 1'b1;
      owner_of[picked[i]] = own;
      bytes_of[picked[i]] = (i + 1 == cnt) ? last_bytes : ps;
    end
    free_count -= cnt;
    used_total += req;
    if (used_total > ByteMax) used_total = ByteMax;
    for (int i = 0; i < cnt; i++)
      push_result(1'b0, 1'b1, picked[i], bytes_of[picked[i]], found, 0, i + 1 == cnt);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t got, exp_r;
    if (!rst_ni) begin
      page_size = PageSizeRst;
      active_frames = ActiveRst;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        used[i] = 1'b0;
        owner_of[i] = '0;
        bytes_of[i] = 0;
      end
      used_total = 0;
      recount();
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      if (result_valid_o) begin
        got = '{status_o, frame_valid_o, frame_index_o, bytes_in_frame_o, contiguous_o,
                freed_bytes_o, free_pages_o, last_o};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, got);
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
            fail_count_o++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'(4 * REG_PAGE_SIZE)) page_size = pwdata[PageSizeW-1:0];
        else if (paddr == 3'(4 * REG_ACTIVE)) begin
          active_frames = pwdata[ActiveW-1:0];
          recount();
        end
      end
      if (start && !busy) predict_request(mode_i, owner_id_i, request_bytes_i);
    end
  end

endmodule

@@ verif/tb_page_frame_allocator.sv @@
// Testbench top for the page frame allocator: clock, reset, request and config stimulus and verdict.
module tb_page_frame_allocator;
  import pfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic mode_i = MODE_ALLOC;
  logic [OwnerW-1:0] owner_id_i = '0;
  logic [ReqW-1:0] request_bytes_i = '0;
  logic result_valid_o, status_o, frame_valid_o, contiguous_o, last_o;
  logic [FrameIdxW-1:0] frame_index_o;
  logic [PageSizeW-1:0] bytes_in_frame_o;
  logic [ReqW-1:0] freed_bytes_o;
  logic [FreePagesW-1:0] free_pages_o;
  int pending, fail_count;
  int unsigned cur_page = 4096;
  int request_count = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  page_frame_allocator DUT (.*);
  pfa_checker u_checker (.*, .pending_o(pending), .fail_count_o(fail_count));

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_request(logic md, logic [OwnerW-1:0] own, logic [ReqW-1:0] req,
                              bit may_idle);
    if (may_idle && $urandom_range(0, 99) < 34) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    @(negedge clk_i);
    mode_i = md;
    owner_id_i = own;
    request_bytes_i = req;
    start = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    request_count++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, int unsigned value);
    drain();
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = 3'(4 * idx);
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == REG_PAGE_SIZE) cur_page = (value[15:0] == 0) ? 1 : value[15:0];
  endtask

  function automatic logic [ReqW-1:0] pick_size();
    int unsigned pages, b;
    if ($urandom_range(0, 9) < 2) return ReqW'($urandom());
    pages = $urandom_range(0, 8);
    if ($urandom_range(0, 19) == 0) pages = $urandom_range(9, 64);
    b = pages * cur_page;
    if (pages != 0) b -= $urandom_range(0, cur_page - 1);
    return (b > ByteMax) ? ByteMax : ReqW'(b);
  endfunction

  initial begin
    int unsigned cfg_page[8] = '{4096, 1, 65535, 0, 100, 4096, 257, 4096};
    int unsigned cfg_active[8] = '{64, 16, 64, 8, 127, 0, 1, 64};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(MODE_ALLOC, 4'd0, '0, 0);
    send_request(MODE_ALLOC, 4'd1, 22'd4096, 0);
    send_request(MODE_ALLOC, 4'd2, 22'd4097, 0);
    send_request(MODE_ALLOC, 4'd15, 22'd8192, 0);
    send_request(MODE_ALLOC, 4'd3, ByteMax, 0);
    send_request(MODE_FREE, 4'd2, ByteMax, 0);
    send_request(MODE_FREE, 4'd9, '0, 0);
    send_request(MODE_ALLOC, 4'd4, 22'd12288, 0);
    send_request(MODE_ALLOC, 4'd4, 22'd1, 0);
    send_request(MODE_FREE, 4'd1, '0, 0);
    send_request(MODE_FREE, 4'd15, '0, 0);
    send_request(MODE_ALLOC, 4'd5, 22'd200000, 0);
    send_request(MODE_FREE, 4'd4, '0, 0);
    send_request(MODE_FREE, 4'd5, '0, 0);
    send_request(MODE_ALLOC, 4'd6, 22'd262144, 0);
    send_request(MODE_FREE, 4'd6, '0, 0);
    for (int i = 0; i < 64; i += 8) send_request(MODE_ALLOC, 4'(i / 8), 22'd4096, 0);
    send_request(MODE_ALLOC, 4'd10, 22'd245760, 0);

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_PAGE_SIZE, cfg_page[ph]);
      write_reg(REG_ACTIVE, cfg_active[ph]);
      for (int k = 0; k < 10; k++) begin
        if (k == 5) drain();
        send_request(($urandom_range(0, 99) < 30) ? MODE_FREE : MODE_ALLOC,
                     OwnerW'($urandom_range(0, 15)), pick_size(), !(ph == 2 || ph == 3));
      end
    end

    drain();
    $display("Ran %0d requests over eight page size and window settings,", request_count);
    $display("including zero sizes, rejects, scattered fallback and empty windows.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
